>>> sv/mlfq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types and fixed constants shared by the feedback queue scheduler files.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int PROC_W    = 8;
  localparam int QUANTUM_W = 9;
  localparam int LIU_W     = 4;

  localparam logic [LIU_W-1:0] LIU_RESET = 4'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_NEXT = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic              has_current;
    logic [PROC_W-1:0] proc_id;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [PROC_W-1:0]    next_proc;
    logic [QUANTUM_W-1:0] quantum;
    logic                 all_empty;
    logic                 overflow;
  } out_item_t;

endpackage
`default_nettype wire

>>> sv/multilevel_feedback_queue_scheduler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler
// Multilevel feedback queue of process ids held in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in channel (in_valid / in_ready, payload in_item).
//   An add request places proc_id at the tail of level 0. A next request may
//   hand back the running process, which is queued one level below the level
//   last dispatched (never beyond the last level in use), and then takes the
//   head of the highest priority non-empty level, with a quantum of
//   2^(level+1). Every request yields exactly one result on the out channel
//   (out_valid / out_ready, payload out_item).
//   A request is handled in two steps: the transfer cycle updates the queue
//   pointers and issues the memory write and read, and the response state,
//   once the output register is free, collects the registered read data
//   into the output register. A new request is taken only after that.
//   The output register holds a finished result, so the next request can be
//   taken while the receiver stalls; a second result then waits until the
//   output register is free. Reset clears all pointers, counts, the last
//   dispatched level and both channels; levels_in_use returns to 4. The id
//   store itself is not cleared, since an entry is only read after it has
//   been written. levels_in_use is written through cfg_write / cfg_data;
//   the user must do so only while idle, as the block does not check it.
// ----------------------------------------------------------------------------
module multilevel_feedback_queue_scheduler #(
  parameter int MAX_LEVELS   = 8,
  parameter int QUEUE_DEPTH  = 16,
  parameter int PROC_ID_BITS = 8
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  mlfq_pkg::in_item_t       in_item,
  output logic                     out_valid,
  input  wire                      out_ready,
  output mlfq_pkg::out_item_t      out_item,
  input  wire                      cfg_write,
  input  wire [mlfq_pkg::LIU_W-1:0] cfg_data
);
  import mlfq_pkg::*;

  localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = $clog2(MAX_LEVELS * QUEUE_DEPTH);
  localparam int DEPTH = MAX_LEVELS * QUEUE_DEPTH;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  // Control state.
  logic                 state;
  logic [LIU_W-1:0]     levels_in_use;
  logic [LW-1:0]        last_level;
  logic [PW-1:0]        level_head  [MAX_LEVELS];
  logic [PW-1:0]        level_tail  [MAX_LEVELS];
  logic [CW-1:0]        level_count [MAX_LEVELS];

  // Id store: one write and one registered read per cycle.
  logic [PROC_ID_BITS-1:0] level_fifo_store [DEPTH];
  logic [PROC_ID_BITS-1:0] rd_data;

  // Result of the transfer cycle, completed once the read data is back.
  logic                    p_found;
  logic [QUANTUM_W-1:0]    p_quantum;
  logic                    p_all_empty;
  logic                    p_overflow;
  logic                    p_fwd;
  logic [PROC_ID_BITS-1:0] p_fwd_id;

  logic                    accept;
  logic [LIU_W-1:0]        n_act;
  logic [LIU_W-1:0]        lv_up;
  logic [LIU_W-1:0]        lv_lim;
  logic [LW-1:0]           push_lvl;
  logic                    do_push;
  logic                    push_ok;
  logic                    push_full;
  logic                    do_pop;
  logic [LW-1:0]           pop_lvl;
  logic [CW-1:0]           cnt_push [MAX_LEVELS];
  logic [CW-1:0]           cnt_next [MAX_LEVELS];
  logic                    empty_next;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic [PROC_ID_BITS-1:0] wr_data;
  logic                    out_free;
  logic [PROC_ID_BITS-1:0] pop_id;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Register values outside 1..MAX_LEVELS are clamped.
  always_comb begin
    if (levels_in_use == '0) begin
      n_act = LIU_W'(1);
    end else if (int'(levels_in_use) > MAX_LEVELS) begin
      n_act = LIU_W'(MAX_LEVELS);
    end else begin
      n_act = levels_in_use;
    end
  end

  // Hand-back goes one level below the last dispatched level, clamped.
  always_comb begin
    lv_up  = LIU_W'(last_level) + LIU_W'(1);
    lv_lim = n_act - LIU_W'(1);
    if (in_item.opcode == OP_ADD) begin
      push_lvl = '0;
    end else if (lv_up > lv_lim) begin
      push_lvl = LW'(lv_lim);
    end else begin
      push_lvl = LW'(lv_up);
    end
  end

  assign do_push   = (in_item.opcode == OP_ADD) || in_item.has_current;
  assign push_full = (level_count[push_lvl] == CW'(QUEUE_DEPTH));
  assign push_ok   = do_push && !push_full;

  // Counts after the enqueue, then the dequeue from the highest priority (lowest numbered) level.
  always_comb begin
    do_pop     = 1'b0;
    pop_lvl    = '0;
    empty_next = 1'b1;
    for (int i = 0; i < MAX_LEVELS; i++) begin
      cnt_push[i] = level_count[i];
      if (push_ok && (push_lvl == LW'(i))) begin
        cnt_push[i] = level_count[i] + CW'(1);
      end
    end
    if (in_item.opcode == OP_NEXT) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        if (!do_pop && (i < int'(n_act)) && (cnt_push[i] != '0)) begin
          do_pop  = 1'b1;
          pop_lvl = LW'(i);
        end
      end
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      cnt_next[i] = cnt_push[i];
      if (do_pop && (pop_lvl == LW'(i))) begin
        cnt_next[i] = cnt_push[i] - CW'(1);
      end
      if ((i < int'(n_act)) && (cnt_next[i] != '0)) begin
        empty_next = 1'b0;
      end
    end
  end

  assign wr_addr = AW'(int'(push_lvl) * QUEUE_DEPTH + int'(level_tail[push_lvl]));
  assign rd_addr = AW'(int'(pop_lvl) * QUEUE_DEPTH + int'(level_head[pop_lvl]));
  assign wr_data = PROC_ID_BITS'(in_item.proc_id);

  always_ff @(posedge clk) begin
    if (accept && push_ok) begin
      level_fifo_store[wr_addr] <= wr_data;
    end
    if (accept && do_pop) begin
      rd_data <= level_fifo_store[rd_addr];
    end
  end

  // Pending result fields; an id pushed into an empty level and popped in
  // the same transfer is forwarded past the memory.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_found     <= do_pop;
      p_quantum   <= do_pop ? (QUANTUM_W'(2) << pop_lvl) : '0;
      p_all_empty <= empty_next;
      p_overflow  <= do_push && push_full;
      p_fwd       <= push_ok && do_pop && (wr_addr == rd_addr);
      p_fwd_id    <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= LIU_RESET;
      last_level    <= '0;
      for (int i = 0; i < MAX_LEVELS; i++) begin
        level_head[i]  <= '0;
        level_tail[i]  <= '0;
        level_count[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        levels_in_use <= cfg_data;
      end
      if (accept) begin
        for (int i = 0; i < MAX_LEVELS; i++) begin
          level_count[i] <= cnt_next[i];
        end
        if (push_ok) begin
          level_tail[push_lvl] <= ptr_inc(level_tail[push_lvl]);
        end
        if (do_pop) begin
          level_head[pop_lvl] <= ptr_inc(level_head[pop_lvl]);
          last_level          <= pop_lvl;
        end
      end
    end
  end

  assign pop_id = p_fwd ? p_fwd_id : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if ((state == S_RESP) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_RESP) && out_free) begin
      out_item.found     <= p_found;
      out_item.next_proc <= p_found ? PROC_W'(pop_id) : '0;
      out_item.quantum   <= p_quantum;
      out_item.all_empty <= p_all_empty;
      out_item.overflow  <= p_overflow;
    end
  end

endmodule
`default_nettype wire

>>> sv/mlfq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks for the feedback queue scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module mlfq_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input mlfq_pkg::out_item_t        out_item
);
  import mlfq_pkg::*;

  // A result without a dispatch carries no id and no quantum.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.found) |-> (out_item.next_proc == '0 && out_item.quantum == '0))
    else $error("result without dispatch has nonzero id or quantum");

  // A dispatch grants a power-of-two quantum of at least two.
  a_quantum: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.found) |-> ($onehot(out_item.quantum) && !out_item.quantum[0]))
    else $error("dispatch quantum is not a power of two of at least two");

  // Requests are taken one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken in the cycle after a transfer");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed or dropped");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (.*);
`default_nettype wire
